/* rtl/trod_pkg.sv */
package trod_pkg;

  // Angle constants in units of 2^-30 rad.
  localparam logic signed [35:0] Pi30     = 36'sd3373259426;
  localparam logic signed [35:0] TwoPi30  = 36'sd6746518852;
  localparam logic signed [35:0] HalfPi30 = 36'sd1686629713;

  // CORDIC datapath width and constants in units of 2^-30.
  localparam int CordW = 34;
  localparam logic signed [CordW-1:0] Gain30 = 34'sd652032874;
  localparam logic signed [CordW-1:0] Lim30  = 34'sd1073741824;
  localparam logic signed [31:0]      One30  = 32'sd1073741824;

  localparam int AtanLen = 24;
  localparam logic [31:0] AtanTab [AtanLen] = '{
    32'd843314856, 32'd497837829, 32'd263043836, 32'd133525158, 32'd67021686,
    32'd33543515, 32'd16775850, 32'd8388437, 32'd4194282, 32'd2097149,
    32'd1048575, 32'd524287, 32'd262143, 32'd131071, 32'd65535, 32'd32767,
    32'd16383, 32'd8191, 32'd4095, 32'd2047, 32'd1023, 32'd511, 32'd255, 32'd127
  };

  // Divider: 37-bit numerator, 16-bit divisor, 24 quotient bits.
  localparam int DivNumW   = 37;
  localparam int DivDenW   = 16;
  localparam int DivQBits  = 24;
  localparam int DivPerStg = 4;
  localparam int DivStages = DivQBits / DivPerStg;

  function automatic logic [31:0] atan_entry(input logic [4:0] idx);
    return AtanTab[idx];
  endfunction

endpackage

/* rtl/trod_cordic.sv */
module trod_cordic import trod_pkg::*; #(
  parameter int STEPS = 16
) (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [33:0] angle_i,
  output logic signed [31:0] cos_o,
  output logic signed [31:0] sin_o
);

  logic signed [35:0] a_ext, a_wrap, a_fold;
  logic               flip_d;

  logic signed [CordW-1:0] x_q [STEPS+1];
  logic signed [CordW-1:0] y_q [STEPS+1];
  logic signed [CordW-1:0] z_q [STEPS+1];
  logic                    flip_q [STEPS+1];

  logic signed [CordW-1:0] xf, yf;
  logic signed [31:0]      cos_q, sin_q;

  // The input never exceeds 2^33, so one wrap brings it into [-pi, pi].
  always_comb begin
    a_ext = {{2{angle_i[33]}}, angle_i};
    if (a_ext > Pi30) begin
      a_wrap = a_ext - TwoPi30;
    end else if (a_ext < -Pi30) begin
      a_wrap = a_ext + TwoPi30;
    end else begin
      a_wrap = a_ext;
    end
    flip_d = 1'b0;
    if (a_wrap > HalfPi30) begin
      a_fold = a_wrap - Pi30;
      flip_d = 1'b1;
    end else if (a_wrap < -HalfPi30) begin
      a_fold = a_wrap + Pi30;
      flip_d = 1'b1;
    end else begin
      a_fold = a_wrap;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]    <= Gain30;
      y_q[0]    <= '0;
      z_q[0]    <= a_fold[CordW-1:0];
      flip_q[0] <= flip_d;
    end
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    logic signed [CordW-1:0] dx, dy, at;
    assign dx = y_q[i] >>> i;
    assign dy = x_q[i] >>> i;
    assign at = {{(CordW-32){1'b0}}, atan_entry(5'(i))};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!z_q[i][CordW-1]) begin
          x_q[i+1] <= x_q[i] - dx;
          y_q[i+1] <= y_q[i] + dy;
          z_q[i+1] <= z_q[i] - at;
        end else begin
          x_q[i+1] <= x_q[i] + dx;
          y_q[i+1] <= y_q[i] - dy;
          z_q[i+1] <= z_q[i] + at;
        end
        flip_q[i+1] <= flip_q[i];
      end
    end
  end

  assign xf = flip_q[STEPS] ? -x_q[STEPS] : x_q[STEPS];
  assign yf = flip_q[STEPS] ? -y_q[STEPS] : y_q[STEPS];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cos_q <= (xf > Lim30) ? One30 : ((xf < -Lim30) ? -One30 : xf[31:0]);
      sin_q <= (yf > Lim30) ? One30 : ((yf < -Lim30) ? -One30 : yf[31:0]);
    end
  end

  assign cos_o = cos_q;
  assign sin_o = sin_q;

endmodule

/* rtl/trod_divider.sv */
module trod_divider import trod_pkg::*; (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic [DivNumW-1:0] num_i,
  input  logic [DivDenW-1:0] den_i,
  output logic [DivQBits-1:0] quo_o,
  output logic               ovf_o
);

  localparam int HiW = DivNumW - DivQBits;

  logic [DivDenW-1:0]  r_q   [DivStages+1];
  logic [DivQBits-1:0] low_q [DivStages+1];
  logic [DivQBits-1:0] q_q   [DivStages+1];
  logic [DivDenW-1:0]  den_q [DivStages+1];
  logic                ovf_q [DivStages+1];

  logic [DivDenW-1:0] hi_part;
  assign hi_part = {{(DivDenW-HiW){1'b0}}, num_i[DivNumW-1:DivQBits]};

  // The quotient fits in DivQBits exactly when the upper numerator bits are
  // below the divisor.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q[0]   <= hi_part;
      low_q[0] <= num_i[DivQBits-1:0];
      q_q[0]   <= '0;
      den_q[0] <= den_i;
      ovf_q[0] <= (hi_part >= den_i);
    end
  end

  for (genvar k = 0; k < DivStages; k++) begin : g_stage
    logic [DivDenW-1:0]  r;
    logic [DivQBits-1:0] low, q;
    logic [DivDenW:0]    t;

    always_comb begin
      r   = r_q[k];
      low = low_q[k];
      q   = q_q[k];
      t   = '0;
      for (int j = 0; j < DivPerStg; j++) begin
        t   = {r, low[DivQBits-1]};
        low = {low[DivQBits-2:0], 1'b0};
        if (t >= {1'b0, den_q[k]}) begin
          t = t - {1'b0, den_q[k]};
          q = {q[DivQBits-2:0], 1'b1};
        end else begin
          q = {q[DivQBits-2:0], 1'b0};
        end
        r = t[DivDenW-1:0];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[k+1]   <= r;
        low_q[k+1] <= low;
        q_q[k+1]   <= q;
        den_q[k+1] <= den_q[k];
        ovf_q[k+1] <= ovf_q[k];
      end
    end
  end

  assign quo_o = q_q[DivStages];
  assign ovf_o = ovf_q[DivStages];

endmodule

/* rtl/turn_rate_odometry_transform_unit.sv */
// Constant turn-rate odometry transform: each request of speed, yaw rate and
// time step yields one result of rotation (cos, sin in Q1.14) and forward and
// rightward displacement (2^-16 m, saturated). The block is a fixed pipeline
// that takes one request per clock while in_ready_o is high. It has one
// stage for the input products, one CORDIC rotation per stage after an angle
// reduction stage, a radius product stage, and a restoring divider that
// resolves four quotient bits per stage. When the output is stalled the
// pipeline still advances as long as its last stage holds no valid result.
module turn_rate_odometry_transform_unit import trod_pkg::*; #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [15:0] speed_i,
  input  logic signed [15:0] yaw_rate_i,
  input  logic [15:0]        delta_t_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] cos_angle_o,
  output logic signed [15:0] sin_angle_o,
  output logic signed [23:0] forward_move_o,
  output logic signed [23:0] right_move_o,
  output logic               stationary_o
);

  localparam int LatC  = CORDIC_STEPS + 2;
  localparam int LatD  = DivStages + 1;
  localparam int Total = LatC + LatD + 2;

  localparam logic RegMinSpeed = 1'b0;
  localparam logic RegMinAngle = 1'b1;

  localparam logic signed [23:0] Max24 = 24'sd8388607;
  localparam logic signed [23:0] Min24 = -24'sd8388608;

  typedef struct packed {
    logic [14:0]        spd;
    logic signed [15:0] yaw;
    logic               stat;
    logic               straight;
    logic [23:0]        fwd_str;
  } side1_t;

  typedef struct packed {
    side1_t             sd;
    logic signed [45:0] num_f;
    logic [45:0]        num_r;
    logic signed [15:0] cos14;
    logic signed [15:0] sin14;
  } mstage_t;

  typedef struct packed {
    logic               stat;
    logic               straight;
    logic [23:0]        fwd_str;
    logic signed [15:0] cos14;
    logic signed [15:0] sin14;
    logic               neg_f;
    logic               neg_r;
  } side2_t;

  // Configuration registers.
  logic [14:0] min_speed_q;
  logic [15:0] min_angle_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_speed_q <= 15'd3;
      min_angle_q <= 16'd268;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        RegMinSpeed: min_speed_q <= pwdata[14:0];
        RegMinAngle: min_angle_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      RegMinSpeed: prdata = {17'b0, min_speed_q};
      RegMinAngle: prdata = {16'b0, min_angle_q};
      default:     prdata = '0;
    endcase
  end

  assign pready = 1'b1;

  // Pipeline control.
  logic [Total-1:0] vld_q;
  logic             out_v_q, out_free, en, v_last;

  assign v_last     = vld_q[Total-1];
  assign out_free   = !out_v_q || out_ready_i;
  assign en         = !v_last || out_free;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Total-2:0], in_valid_i};
    end
  end

  // Stage 0: turn angle and straight-line product.
  logic signed [32:0] alpha_full;
  logic [30:0]        prod_d;
  logic signed [31:0] alpha_q;
  logic [30:0]        prod_q;
  logic [14:0]        spd_q;
  logic signed [15:0] yaw_q;
  logic               stat_q;

  assign alpha_full = $signed({{17{yaw_rate_i[15]}}, yaw_rate_i}) * $signed({17'b0, delta_t_i});
  assign prod_d     = {16'b0, speed_i[14:0]} * {15'b0, delta_t_i};

  always_ff @(posedge clk_i) begin
    if (en) begin
      alpha_q <= alpha_full[31:0];
      prod_q  <= prod_d;
      spd_q   <= speed_i[14:0];
      yaw_q   <= yaw_rate_i;
      stat_q  <= speed_i[15] || (speed_i[14:0] < min_speed_q);
    end
  end

  // Side data travels next to the CORDIC.
  logic [31:0] aabs;
  logic [31:0] fwd_round;
  side1_t      side1_d;
  side1_t      side1_q [LatC];

  assign aabs      = alpha_q[31] ? 32'(-alpha_q) : 32'(alpha_q);
  assign fwd_round = {1'b0, prod_q} + 32'd128;

  always_comb begin
    side1_d.spd      = spd_q;
    side1_d.yaw      = yaw_q;
    side1_d.stat     = stat_q;
    side1_d.straight = (aabs < {16'b0, min_angle_q}) || (yaw_q == 16'sd0);
    side1_d.fwd_str  = fwd_round[31:8];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side1_q[0] <= side1_d;
      for (int k = 1; k < LatC; k++) begin
        side1_q[k] <= side1_q[k-1];
      end
    end
  end

  logic signed [31:0] c30, s30;

  trod_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk_i   (clk_i),
    .en_i    (en),
    .angle_i ({alpha_q, 2'b00}),
    .cos_o   (c30),
    .sin_o   (s30)
  );

  // Radius products and Q1.14 rounding.
  side1_t             sc;
  logic signed [46:0] num_f_full;
  logic signed [32:0] omc_s;
  logic [45:0]        num_r_d;
  logic signed [32:0] cs_sum, ss_sum;
  mstage_t            m_q;

  assign sc         = side1_q[LatC-1];
  assign num_f_full = $signed({32'b0, sc.spd}) * $signed({{15{s30[31]}}, s30});
  assign omc_s      = $signed({One30[31], One30}) - $signed({c30[31], c30});
  assign num_r_d    = {31'b0, sc.spd} * {14'b0, omc_s[31:0]};
  assign cs_sum     = $signed({c30[31], c30}) + 33'sd32768;
  assign ss_sum     = $signed({s30[31], s30}) + 33'sd32768;

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_q.sd    <= sc;
      m_q.num_f <= num_f_full[45:0];
      m_q.num_r <= num_r_d;
      m_q.cos14 <= cs_sum[31:16];
      m_q.sin14 <= ss_sum[31:16];
    end
  end

  // Rounding offset of half the divisor; the divisor carries ten zero bits
  // that are dropped from both sides.
  logic [15:0]        yaw_abs;
  logic [45:0]        an_f;
  logic [46:0]        sum_f, sum_r;
  side2_t             side2_d;
  side2_t             side2_q [LatD];

  assign yaw_abs = m_q.sd.yaw[15] ? 16'(-m_q.sd.yaw) : 16'(m_q.sd.yaw);
  assign an_f    = m_q.num_f[45] ? 46'(-m_q.num_f) : 46'(m_q.num_f);
  assign sum_f   = {1'b0, an_f} + {22'b0, yaw_abs, 9'b0};
  assign sum_r   = {1'b0, m_q.num_r} + {22'b0, yaw_abs, 9'b0};

  always_comb begin
    side2_d.stat     = m_q.sd.stat;
    side2_d.straight = m_q.sd.straight;
    side2_d.fwd_str  = m_q.sd.fwd_str;
    side2_d.cos14    = m_q.cos14;
    side2_d.sin14    = m_q.sin14;
    side2_d.neg_f    = m_q.num_f[45] ^ m_q.sd.yaw[15];
    side2_d.neg_r    = m_q.sd.yaw[15];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side2_q[0] <= side2_d;
      for (int k = 1; k < LatD; k++) begin
        side2_q[k] <= side2_q[k-1];
      end
    end
  end

  logic [DivQBits-1:0] quo_f, quo_r;
  logic                ovf_f, ovf_r;

  trod_divider u_div_fwd (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (sum_f[46:10]),
    .den_i (yaw_abs),
    .quo_o (quo_f),
    .ovf_o (ovf_f)
  );

  trod_divider u_div_rgt (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (sum_r[46:10]),
    .den_i (yaw_abs),
    .quo_o (quo_r),
    .ovf_o (ovf_r)
  );

  function automatic logic signed [23:0] sat_quo(input logic [23:0] q, input logic ovf,
                                                 input logic neg);
    if (ovf || q[23]) begin
      return neg ? Min24 : Max24;
    end
    return neg ? -$signed(q) : $signed(q);
  endfunction

  // Output register.
  side2_t             so;
  logic signed [15:0] cos_q, sin_q;
  logic signed [23:0] fwd_q, rgt_q;
  logic               stat_out_q;

  assign so = side2_q[LatD-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_free) begin
      out_v_q <= v_last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && v_last) begin
      if (so.stat) begin
        cos_q      <= 16'sd16384;
        sin_q      <= '0;
        fwd_q      <= '0;
        rgt_q      <= '0;
        stat_out_q <= 1'b1;
      end else begin
        cos_q      <= so.cos14;
        sin_q      <= so.sin14;
        fwd_q      <= so.straight ? $signed(so.fwd_str) : sat_quo(quo_f, ovf_f, so.neg_f);
        rgt_q      <= so.straight ? 24'sd0 : sat_quo(quo_r, ovf_r, so.neg_r);
        stat_out_q <= 1'b0;
      end
    end
  end

  assign out_valid_o    = out_v_q;
  assign cos_angle_o    = cos_q;
  assign sin_angle_o    = sin_q;
  assign forward_move_o = fwd_q;
  assign right_move_o   = rgt_q;
  assign stationary_o   = stat_out_q;

`ifndef SYNTHESIS
  a_stat_identity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && stationary_o |-> cos_angle_o == 16'sd16384 && sin_angle_o == 16'sd0 &&
      forward_move_o == 24'sd0 && right_move_o == 24'sd0)
    else $error("stationary result is not the identity motion");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("request refused without a blocked result");

  a_cos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> cos_angle_o <= 16'sd16384 && cos_angle_o >= -16'sd16384)
    else $error("cosine out of range");

  a_sin_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> sin_angle_o <= 16'sd16384 && sin_angle_o >= -16'sd16384)
    else $error("sine out of range");
`endif

endmodule
